@@ sv/id3s_pkg.sv @@
// Shared types, constants and table-generation function for the ID3 split selector.
`timescale 1ns / 1ps
package id3s_pkg;

   localparam int BIN_COUNT = 10;
   localparam int FIELD_CNT_W = 11;
   localparam int ENT_W = 16;
   localparam int LOG_FRAC = 24;

   typedef enum logic [1:0] {
      DEC_SPLIT = 2'd0,
      DEC_PURE  = 2'd1,
      DEC_EMPTY = 2'd2,
      DEC_NONE  = 2'd3
   } decision_type;

   // classified sample moving from the front end to the back end
   typedef struct packed {
      logic                 ok;
      logic [BIN_COUNT-1:0] bin_mask;
      logic                 positive;
      logic                 last;
   } item_type;

   function automatic logic [3:0] attr_first(input logic [1:0] a);
      logic [3:0] r;
      unique case (a)
         2'd0: r = 4'd0;
         2'd1: r = 4'd3;
         2'd2: r = 4'd6;
         2'd3: r = 4'd8;
         default: r = 4'd0;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] attr_last(input logic [1:0] a);
      logic [3:0] r;
      unique case (a)
         2'd0: r = 4'd2;
         2'd1: r = 4'd5;
         2'd2: r = 4'd7;
         2'd3: r = 4'd9;
         default: r = 4'd9;
      endcase
      return r;
   endfunction

   // -p*log2(p) term for p = k/2^bits, Q1.15; evaluated at elaboration only
   function automatic logic [15:0] ent_entry(input int unsigned k, input int unsigned bits);
      logic [63:0] m;
      logic [63:0] frac;
      logic [63:0] diff;
      logic [63:0] prod;
      logic [63:0] kk;
      int unsigned n;
      int unsigned sh;
      if (k == 0) return 16'd0;
      n = 0;
      while ((k >> (n + 1)) != 0) n++;
      kk = 64'(k);
      m = kk << (30 - n);
      frac = 64'd0;
      for (int i = 0; i < LOG_FRAC; i++) begin
         m = (m * m) >> 30;
         if (m >= 64'h0000_0000_8000_0000) begin
            m = m >> 1;
            frac = frac | (64'd1 << (LOG_FRAC - 1 - i));
         end
      end
      diff = (64'(bits) << LOG_FRAC) - ((64'(n) << LOG_FRAC) | frac);
      prod = kk * diff;
      sh = bits + LOG_FRAC - 15;
      return 16'((prod + (64'd1 << (sh - 1))) >> sh);
   endfunction

endpackage

@@ sv/id3s_front.sv @@
// Front end: range-checks a sample and maps its attribute values to counter bins.
`timescale 1ns / 1ps
module id3s_front (
   input  logic                start,
   input  logic                busy,
   input  logic                req_sample_valid,
   input  logic [1:0]          req_age_value,
   input  logic [1:0]          req_income_value,
   input  logic [1:0]          req_student_value,
   input  logic [1:0]          req_reputation_value,
   input  logic                req_class_label,
   input  logic                req_last_sample,
   output logic                push,
   output id3s_pkg::item_type  item
);

   logic in_range;

   assign in_range = (req_age_value != 2'd0) && (req_income_value != 2'd0) &&
                     (req_student_value == 2'd1 || req_student_value == 2'd2) &&
                     (req_reputation_value == 2'd1 || req_reputation_value == 2'd2);

   always_comb begin
      item = '0;
      item.ok = req_sample_valid && in_range;
      item.positive = req_class_label;
      item.last = req_last_sample;
      item.bin_mask[0] = req_age_value == 2'd1;
      item.bin_mask[1] = req_age_value == 2'd2;
      item.bin_mask[2] = req_age_value == 2'd3;
      item.bin_mask[3] = req_income_value == 2'd1;
      item.bin_mask[4] = req_income_value == 2'd2;
      item.bin_mask[5] = req_income_value == 2'd3;
      item.bin_mask[6] = req_student_value == 2'd1;
      item.bin_mask[7] = req_student_value == 2'd2;
      item.bin_mask[8] = req_reputation_value == 2'd1;
      item.bin_mask[9] = req_reputation_value == 2'd2;
   end

   assign push = start && !busy;

endmodule

@@ sv/id3s_queue.sv @@
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
module id3s_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  id3s_pkg::item_type  push_item,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output id3s_pkg::item_type  head
);

   id3s_pkg::item_type mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_pop;

   assign full = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;
   assign do_pop = pop && !empty;
   assign head = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(do_pop);
      end
   end

endmodule

@@ sv/id3s_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module id3s_div #(
   parameter int NW = 30,
   parameter int DW = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] numerator,
   input  logic [DW-1:0] denominator,
   output logic          done,
   output logic [NW-1:0] quotient
);

   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] quo_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] den_ff;
   logic [CW-1:0] cnt_ff;
   logic          done_ff;
   logic [DW:0]   shifted;
   logic          fits;

   assign shifted = {rem_ff, quo_ff[NW-1]};
   assign fits = shifted >= {1'b0, den_ff};
   assign done = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= numerator;
         rem_ff <= '0;
         den_ff <= denominator;
      end else if (cnt_ff != '0) begin
         rem_ff <= fits ? DW'(shifted - {1'b0, den_ff}) : DW'(shifted);
         quo_ff <= {quo_ff[NW-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff <= CW'(NW);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - CW'(1);
         done_ff <= cnt_ff == CW'(1);
      end else begin
         done_ff <= 1'b0;
      end
   end

endmodule

@@ sv/id3s_back.sv @@
// Back end: bin counters and the per-node entropy sequencer.
`timescale 1ns / 1ps
module id3s_back #(
   parameter int MAX_SAMPLES = 1024,
   parameter int PROB_TABLE_BITS = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  id3s_pkg::item_type  head,
   output logic                pop,
   input  logic [3:0]          attribute_enable,
   output logic                rsp_valid,
   output logic [1:0]          rsp_decision,
   output logic [1:0]          rsp_split_attribute,
   output logic                rsp_majority_label,
   output logic [15:0]         rsp_best_entropy,
   output logic [10:0]         rsp_node_total,
   output logic [10:0]         rsp_positive_count
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W = CNT_W + 18;
   localparam int MUL_W = CNT_W + 17;
   localparam int NW = CNT_W + 19;
   localparam int AW = PROB_TABLE_BITS + 1;
   localparam int ROM_SIZE = (1 << PROB_TABLE_BITS) + 1;
   localparam int E_W = 17;

   typedef logic [15:0] rom_type [ROM_SIZE];

   function automatic rom_type build_rom();
      rom_type r;
      for (int k = 0; k < ROM_SIZE; k++) begin
         r[k] = id3s_pkg::ent_entry(k, PROB_TABLE_BITS);
      end
      return r;
   endfunction

   localparam rom_type ROM = build_rom();

   typedef enum logic [9:0] {
      ST_COUNT  = 10'b00_0000_0001,
      ST_DECIDE = 10'b00_0000_0010,
      ST_BIN    = 10'b00_0000_0100,
      ST_QWAIT  = 10'b00_0000_1000,
      ST_TA     = 10'b00_0001_0000,
      ST_TB     = 10'b00_0010_0000,
      ST_ACC    = 10'b00_0100_0000,
      ST_ENDA   = 10'b00_1000_0000,
      ST_EWAIT  = 10'b01_0000_0000,
      ST_OUT    = 10'b10_0000_0000
   } state_type;

   state_type state_ff;
   logic [CNT_W-1:0] vt_ff [id3s_pkg::BIN_COUNT];
   logic [CNT_W-1:0] vp_ff [id3s_pkg::BIN_COUNT];
   logic [CNT_W-1:0] nt_ff;
   logic [CNT_W-1:0] np_ff;
   logic [1:0]       attr_ff;
   logic [3:0]       bin_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [AW-1:0]    q_ff;
   logic [15:0]      t1_ff;
   logic [15:0]      rom_data_ff;
   logic [E_W-1:0]   best_ff;
   logic [1:0]       best_attr_ff;
   logic             have_best_ff;
   id3s_pkg::decision_type dec_ff;

   logic             counting;
   logic             do_count;
   logic [AW-1:0]    rom_addr;
   logic [CNT_W-1:0] bin_n;
   logic [CNT_W-1:0] bin_p;
   logic             div_start;
   logic [NW-1:0]    div_num;
   logic [CNT_W-1:0] div_den;
   logic             div_done;
   logic [NW-1:0]    div_quo;
   logic [E_W-1:0]   e_val;
   logic [16:0]      ent_sum;

   assign counting = state_ff == ST_COUNT;
   assign pop = counting && !queue_empty;
   assign do_count = pop && head.ok && (nt_ff < CNT_W'(MAX_SAMPLES));
   assign bin_n = vt_ff[bin_ff];
   assign bin_p = vp_ff[bin_ff];
   assign ent_sum = 17'(t1_ff) + 17'(rom_data_ff);
   assign e_val = E_W'(div_quo);

   always_comb begin
      div_start = 1'b0;
      div_num = NW'(bin_p) << PROB_TABLE_BITS;
      div_num = div_num + NW'(bin_n >> 1);
      div_den = bin_n;
      if (state_ff == ST_BIN && attribute_enable[attr_ff] && bin_n != '0) begin
         div_start = 1'b1;
      end
      if (state_ff == ST_ENDA) begin
         div_start = 1'b1;
         div_num = NW'(sum_ff) + NW'(nt_ff >> 1);
         div_den = nt_ff;
      end
   end

   always_comb begin
      rom_addr = q_ff;
      if (state_ff == ST_TB) rom_addr = AW'(1 << PROB_TABLE_BITS) - q_ff;
   end

   always_ff @(posedge clock) begin
      rom_data_ff <= ROM[rom_addr];
   end

   id3s_div #(.NW(NW), .DW(CNT_W)) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .numerator(div_num),
      .denominator(div_den),
      .done(div_done),
      .quotient(div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COUNT;
         nt_ff <= '0;
         np_ff <= '0;
         rsp_valid <= 1'b0;
         for (int b = 0; b < id3s_pkg::BIN_COUNT; b++) begin
            vt_ff[b] <= '0;
            vp_ff[b] <= '0;
         end
      end else begin
         rsp_valid <= 1'b0;
         unique case (state_ff)
            ST_COUNT: begin
               if (do_count) begin
                  nt_ff <= nt_ff + CNT_W'(1);
                  np_ff <= np_ff + CNT_W'(head.positive);
                  for (int b = 0; b < id3s_pkg::BIN_COUNT; b++) begin
                     if (head.bin_mask[b]) begin
                        vt_ff[b] <= vt_ff[b] + CNT_W'(1);
                        vp_ff[b] <= vp_ff[b] + CNT_W'(head.positive);
                     end
                  end
               end
               if (pop && head.last) state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               attr_ff <= 2'd0;
               bin_ff <= id3s_pkg::attr_first(2'd0);
               sum_ff <= '0;
               have_best_ff <= 1'b0;
               best_ff <= '0;
               best_attr_ff <= 2'd0;
               priority if (attribute_enable == 4'd0) begin
                  dec_ff <= id3s_pkg::DEC_NONE;
                  state_ff <= ST_OUT;
               end else if (nt_ff == '0) begin
                  dec_ff <= id3s_pkg::DEC_EMPTY;
                  state_ff <= ST_OUT;
               end else if (np_ff == '0 || np_ff == nt_ff) begin
                  dec_ff <= id3s_pkg::DEC_PURE;
                  state_ff <= ST_OUT;
               end else begin
                  dec_ff <= id3s_pkg::DEC_SPLIT;
                  state_ff <= ST_BIN;
               end
            end
            ST_BIN: begin
               priority if (!attribute_enable[attr_ff]) begin
                  if (attr_ff == 2'd3) begin
                     state_ff <= ST_OUT;
                  end else begin
                     attr_ff <= attr_ff + 2'd1;
                     bin_ff <= id3s_pkg::attr_first(attr_ff + 2'd1);
                  end
               end else if (bin_n != '0) begin
                  state_ff <= ST_QWAIT;
               end else if (bin_ff == id3s_pkg::attr_last(attr_ff)) begin
                  state_ff <= ST_ENDA;
               end else begin
                  bin_ff <= bin_ff + 4'd1;
               end
            end
            ST_QWAIT: begin
               if (div_done) begin
                  q_ff <= (div_quo > NW'(1 << PROB_TABLE_BITS)) ?
                          AW'(1 << PROB_TABLE_BITS) : AW'(div_quo);
                  state_ff <= ST_TA;
               end
            end
            ST_TA: state_ff <= ST_TB;
            ST_TB: begin
               t1_ff <= rom_data_ff;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               sum_ff <= sum_ff + SUM_W'(MUL_W'(bin_n) * MUL_W'(ent_sum));
               if (bin_ff == id3s_pkg::attr_last(attr_ff)) begin
                  state_ff <= ST_ENDA;
               end else begin
                  bin_ff <= bin_ff + 4'd1;
                  state_ff <= ST_BIN;
               end
            end
            ST_ENDA: state_ff <= ST_EWAIT;
            ST_EWAIT: begin
               if (div_done) begin
                  sum_ff <= '0;
                  if (!have_best_ff || e_val < best_ff) begin
                     have_best_ff <= 1'b1;
                     best_ff <= e_val;
                     best_attr_ff <= attr_ff;
                  end
                  if (attr_ff == 2'd3) begin
                     state_ff <= ST_OUT;
                  end else begin
                     attr_ff <= attr_ff + 2'd1;
                     bin_ff <= id3s_pkg::attr_first(attr_ff + 2'd1);
                     state_ff <= ST_BIN;
                  end
               end
            end
            ST_OUT: begin
               rsp_valid <= 1'b1;
               rsp_decision <= dec_ff;
               rsp_split_attribute <= (dec_ff == id3s_pkg::DEC_SPLIT) ? best_attr_ff : 2'd0;
               rsp_best_entropy <= (dec_ff == id3s_pkg::DEC_SPLIT) ? 16'(best_ff) : 16'd0;
               rsp_majority_label <= ({1'b0, np_ff, 1'b0} >= {2'b00, nt_ff});
               rsp_node_total <= 11'(nt_ff);
               rsp_positive_count <= 11'(np_ff);
               nt_ff <= '0;
               np_ff <= '0;
               for (int b = 0; b < id3s_pkg::BIN_COUNT; b++) begin
                  vt_ff[b] <= '0;
                  vp_ff[b] <= '0;
               end
               state_ff <= ST_COUNT;
            end
            default: state_ff <= ST_COUNT;
         endcase
      end
   end

endmodule

@@ sv/id3_split_attribute_selector_top.sv @@
// Top level of the ID3 split attribute selector.
// Samples of one tree node enter on the req_ ports: a transaction is taken
// at a clock edge where start is high and busy is low. Samples may come
// back to back; a two-entry queue decouples the intake from the counting
// back end. The transaction marked req_last_sample closes the node. The
// back end then runs the entropy pass: for every nonempty bin of an enabled
// attribute one divider run plus a table lookup and accumulate, and per
// enabled attribute one more divider run. Trivial nodes (pure, empty,
// nothing enabled) skip the pass. The divider sets the pace.
// While the pass runs, busy rises as soon as the queue fills.
// The result appears for one cycle with rsp_valid high; it cannot be stalled.
// csr_write_enable writes attribute_enable (read from node close until the result).
// Reset clears the counters, the queue and sets attribute_enable to all ones.
`timescale 1ns / 1ps
module id3_split_attribute_selector_top #(
   parameter int MAX_SAMPLES = 1024,
   parameter int PROB_TABLE_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_sample_valid,
   input  logic [1:0]  req_age_value,
   input  logic [1:0]  req_income_value,
   input  logic [1:0]  req_student_value,
   input  logic [1:0]  req_reputation_value,
   input  logic        req_class_label,
   input  logic        req_last_sample,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_write_data,
   output logic        rsp_valid,
   output logic [1:0]  rsp_decision,
   output logic [1:0]  rsp_split_attribute,
   output logic        rsp_majority_label,
   output logic [15:0] rsp_best_entropy,
   output logic [10:0] rsp_node_total,
   output logic [10:0] rsp_positive_count
);

   logic [3:0]         attribute_enable_ff;
   logic               push;
   logic               pop;
   logic               q_empty;
   id3s_pkg::item_type push_item;
   id3s_pkg::item_type head;

   always_ff @(posedge clock) begin
      if (reset) begin
         attribute_enable_ff <= 4'hF;
      end else if (csr_write_enable) begin
         attribute_enable_ff <= csr_write_data;
      end
   end

   id3s_front u_front (
      .start(start),
      .busy(busy),
      .req_sample_valid(req_sample_valid),
      .req_age_value(req_age_value),
      .req_income_value(req_income_value),
      .req_student_value(req_student_value),
      .req_reputation_value(req_reputation_value),
      .req_class_label(req_class_label),
      .req_last_sample(req_last_sample),
      .push(push),
      .item(push_item)
   );

   id3s_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_item(push_item),
      .pop(pop),
      .full(busy),
      .empty(q_empty),
      .head(head)
   );

   id3s_back #(.MAX_SAMPLES(MAX_SAMPLES), .PROB_TABLE_BITS(PROB_TABLE_BITS)) u_back (
      .clock(clock),
      .reset(reset),
      .queue_empty(q_empty),
      .head(head),
      .pop(pop),
      .attribute_enable(attribute_enable_ff),
      .rsp_valid(rsp_valid),
      .rsp_decision(rsp_decision),
      .rsp_split_attribute(rsp_split_attribute),
      .rsp_majority_label(rsp_majority_label),
      .rsp_best_entropy(rsp_best_entropy),
      .rsp_node_total(rsp_node_total),
      .rsp_positive_count(rsp_positive_count)
   );

endmodule
